>>> sv/mlpq_pkg.sv
// Shared types and constants for the multilevel priority queue.
package mlpq_pkg;

  localparam int NUM_W  = 16;
  localparam int PRIO_W = 4;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SERVE  = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } mlpq_status_t;

  // Outcome of one request as decided by the level controller.
  typedef struct packed {
    mlpq_status_t             status;
    logic [PRIO_W-1:0]        level;
  } mlpq_res_t;

endpackage

>>> sv/mlpq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mlpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/mlpq_ctrl.sv
// Per-level head pointers and fill counts, top-level encoder and store addressing.
module mlpq_ctrl
  import mlpq_pkg::*;
#(
  parameter int LEVELS      = 10,
  parameter int LEVEL_DEPTH = 16,
  parameter int ADDR_W      = $clog2(LEVELS * LEVEL_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              req_type,
  input  logic [PRIO_W-1:0] req_priority,
  output mlpq_res_t         res,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr
);

  localparam int LVL_W = $clog2(LEVELS);
  localparam int PTR_W = $clog2(LEVEL_DEPTH);
  localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);

  logic [PTR_W-1:0] head  [LEVELS];
  logic [CNT_W-1:0] count [LEVELS];

  logic             lvl_ok;
  logic [LVL_W-1:0] ins_idx;
  logic             lvl_full;
  logic             found;
  logic [LVL_W-1:0] top;
  logic [PTR_W:0]   slot_sum;
  logic [PTR_W-1:0] ins_slot;
  logic [PTR_W-1:0] head_inc;
  logic             do_insert;
  logic             do_serve;

  assign lvl_ok   = {1'b0, req_priority} < (PRIO_W + 1)'(LEVELS);
  assign ins_idx  = lvl_ok ? req_priority[LVL_W-1:0] : '0;
  assign lvl_full = count[ins_idx] == CNT_W'(LEVEL_DEPTH);

  // Highest non-empty level wins.
  always_comb begin
    found = 1'b0;
    top   = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (count[i] != '0) begin
        found = 1'b1;
        top   = LVL_W'(i);
      end
    end
  end

  // Tail slot: head plus count, wrapped once (count is below the depth here).
  assign slot_sum = {1'b0, head[ins_idx]} + (PTR_W + 1)'(count[ins_idx][PTR_W-1:0]);
  assign ins_slot = (slot_sum >= (PTR_W + 1)'(LEVEL_DEPTH))
                  ? PTR_W'(slot_sum - (PTR_W + 1)'(LEVEL_DEPTH))
                  : slot_sum[PTR_W-1:0];
  assign head_inc = (head[top] == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : head[top] + 1'b1;

  assign do_insert = accept && (req_type == REQ_INSERT) && lvl_ok && !lvl_full;
  assign do_serve  = accept && (req_type == REQ_SERVE) && found;

  assign ram_we    = do_insert;
  assign ram_waddr = ADDR_W'(ADDR_W'(ins_idx) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(ins_slot);
  assign ram_re    = do_serve;
  assign ram_raddr = ADDR_W'(ADDR_W'(top) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(head[top]);

  always_comb begin
    res.level = '0;
    if (req_type == REQ_INSERT) begin
      res.status = (lvl_ok && !lvl_full) ? ST_INSERTED : ST_FULL;
    end else if (found) begin
      res.status = ST_SERVED;
      res.level  = PRIO_W'(top);
    end else begin
      res.status = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (do_insert) begin
        count[ins_idx] <= count[ins_idx] + 1'b1;
      end
      if (do_serve) begin
        head[top]  <= head_inc;
        count[top] <= count[top] - 1'b1;
      end
    end
  end

endmodule

>>> sv/multilevel_priority_queue_unit.sv
// Multilevel FIFO priority queue: one bounded FIFO per level, highest level served first.
// The queue takes one request per clock cycle while in_ready is high and returns one
// result per request, through the pending stage with the entry store's registered read
// and then the output register. Head pointers and fill counts of all levels sit in
// flip-flops and are cleared by reset, so the queue is ready as soon as reset is released;
// the entry store is a single RAM of LEVELS*LEVEL_DEPTH words that is written by
// an insert and read by a serve, one access per request. A serve returns the oldest entry
// of the highest non-empty level; a serve on an empty queue reports empty, an insert into
// a full level or a level at or above LEVELS reports full and drops the request.
module multilevel_priority_queue_unit
  import mlpq_pkg::*;
#(
  parameter int LEVELS      = 10,
  parameter int LEVEL_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [NUM_W-1:0]  req_number,
  input  logic [PRIO_W-1:0] req_priority,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [NUM_W-1:0]  served_number,
  output logic [PRIO_W-1:0] served_priority
);

  localparam int STORE_W = (ID_BITS < NUM_W) ? ID_BITS : NUM_W;
  localparam int DEPTH   = LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W  = $clog2(DEPTH);

  logic              accept;
  logic              move;
  logic              pend_valid;
  mlpq_res_t         pend_res;
  mlpq_res_t         res;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [STORE_W-1:0] ram_rdata;

  assign move     = pend_valid && (!out_valid || out_ready);
  assign in_ready = !pend_valid || move;
  assign accept   = in_valid && in_ready;

  mlpq_ctrl #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .req_type     (req_type),
    .req_priority (req_priority),
    .res          (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr)
  );

  mlpq_ram #(
    .WIDTH (STORE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req_number[STORE_W-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Pending stage waits for the store read; read data holds while it stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      status          <= pend_res.status;
      served_priority <= pend_res.level;
      served_number   <= (pend_res.status == ST_SERVED) ? NUM_W'(ram_rdata) : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_serve_outcome: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == REQ_SERVE |=>
      pend_res.status == ST_SERVED || pend_res.status == ST_EMPTY)
    else $error("serve request decided as insert outcome");

  a_served_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_SERVED |-> {1'b0, served_priority} < (PRIO_W + 1)'(LEVELS))
    else $error("served level out of range");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_SERVED |-> served_number == '0 && served_priority == '0)
    else $error("non-serve result carries data");

  a_ram_single: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("store written and read by one request");
`endif

endmodule
